/* src/nfcs_pkg.sv */
`timescale 1ns / 1ps
package nfcs_pkg;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_P_CHECK   = 7'b0000010,
    PH_P_POLL    = 7'b0000100,
    PH_P_RECHECK = 7'b0001000,
    PH_P_VERIFY  = 7'b0010000,
    PH_E_POLL    = 7'b0100000,
    PH_S_WAIT    = 7'b1000000
  } phase_t;

  localparam logic [2:0] K_PROGRAM = 3'd0;
  localparam logic [2:0] K_ERASE   = 3'd1;
  localparam logic [2:0] K_SECSI   = 3'd2;
  localparam logic [2:0] K_RESP    = 3'd3;
  localparam logic [2:0] K_TICK    = 3'd4;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_ERASED = 3'd1;
  localparam logic [2:0] ST_PROTECTED  = 3'd2;
  localparam logic [2:0] ST_INVALID    = 3'd3;
  localparam logic [2:0] ST_PROG_ERR   = 3'd4;
  localparam logic [2:0] ST_TIMEOUT    = 3'd5;
  localparam logic [2:0] ST_BAD_BANK   = 3'd6;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PROT_LO = 2'd1;
  localparam logic [1:0] REG_PROT_HI = 2'd2;

  localparam logic [22:0] UNLOCK_A1 = 23'h000AAA;
  localparam logic [22:0] UNLOCK_A2 = 23'h000554;
  localparam logic [15:0] CMD_AA = 16'h00AA;
  localparam logic [15:0] CMD_55 = 16'h0055;
  localparam logic [15:0] CMD_80 = 16'h0080;
  localparam logic [15:0] CMD_30 = 16'h0030;
  localparam logic [15:0] CMD_A0 = 16'h00A0;
  localparam logic [15:0] CMD_F0 = 16'h00F0;
  localparam logic [15:0] CMD_88 = 16'h0088;
  localparam logic [15:0] CMD_90 = 16'h0090;
  localparam logic [15:0] CMD_00 = 16'h0000;

  localparam int MAX_RES = 8;

  // one result word: op, address, data, done, status, byte
  typedef struct packed {
    logic [1:0]  op;
    logic [22:0] addr;
    logic [15:0] data;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  rbyte;
  } res_t;

  // burst of results produced by one input word
  typedef struct packed {
    logic [3:0]               count;
    res_t [MAX_RES-1:0]       item;
  } burst_t;

  function automatic res_t mk_wr(input logic [22:0] a, input logic [15:0] d);
    res_t r;
    r = '0;
    r.op = OP_WRITE;
    r.addr = a;
    r.data = d;
    return r;
  endfunction

  function automatic res_t mk_rd(input logic [22:0] a);
    res_t r;
    r = '0;
    r.op = OP_READ;
    r.addr = a;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [2:0] st, input logic [7:0] b);
    res_t r;
    r = '0;
    r.done = 1'b1;
    r.status = st;
    r.rbyte = b;
    return r;
  endfunction

endpackage

/* src/nfcs_core.sv */
`timescale 1ns / 1ps
module nfcs_core import nfcs_pkg::*; #(
  parameter int NUM_SECTORS        = 71,
  parameter int PARAM_SECTOR_BYTES = 4096,
  parameter int MAIN_SECTOR_BYTES  = 65536,
  parameter int FLASH_BYTES        = 8388608
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [2:0]   kind,
  input  logic [22:0]  address,
  input  logic [15:0]  data,
  input  logic [6:0]   first_sector,
  input  logic [6:0]   last_sector,
  input  logic [1:0]   bank,
  input  logic [15:0]  read_data,
  input  logic [31:0]  timeout_ticks,
  input  logic [127:0] protect,
  output burst_t       burst
);

  localparam logic [22:0] AMASK = 23'((64'(FLASH_BYTES) - 64'd1) & 64'h7FFFFF);

  phase_t      phase, phase_next;
  logic [6:0]  current_sector, current_sector_next;
  logic [6:0]  end_sector, end_sector_next;
  logic [22:0] target_address, target_address_next;
  logic [15:0] program_value, program_value_next;
  logic [31:0] elapsed_ticks, elapsed_ticks_next;
  logic        odd_byte, odd_byte_next;

  function automatic logic [22:0] sec_start(input logic [6:0] s);
    logic [31:0] a;
    if (s <= 7'd7) a = 32'(s) * 32'(PARAM_SECTOR_BYTES);
    else a = 32'(s - 7'd7) * 32'(MAIN_SECTOR_BYTES);
    return a[22:0] & AMASK;
  endfunction

  logic [22:0] addr_w;
  logic        range_bad, range_prot;
  logic [127:0] lo_mask, hi_mask, cnt_mask;
  logic [6:0]  nxt_sec;
  logic [22:0] cur_sa, nxt_sa, first_sa;
  logic        timed_out;

  always_comb begin
    addr_w = address & AMASK;
    range_bad = (first_sector > last_sector) || (32'(last_sector) >= 32'(NUM_SECTORS));
    lo_mask = ~128'd0 << first_sector;
    hi_mask = ~128'd0 >> (7'd127 - last_sector);
    cnt_mask = (NUM_SECTORS >= 71) ? {57'd0, {71{1'b1}}} : ~128'd0;
    range_prot = |(protect & lo_mask & hi_mask & cnt_mask);
    nxt_sec = current_sector + 7'd1;
    cur_sa = sec_start(current_sector);
    nxt_sa = sec_start(nxt_sec);
    first_sa = sec_start(first_sector);
    timed_out = elapsed_ticks > timeout_ticks;
  end

  // decode one word into a burst and the next state
  always_comb begin
    burst = '0;
    phase_next = phase;
    current_sector_next = current_sector;
    end_sector_next = end_sector;
    target_address_next = target_address;
    program_value_next = program_value;
    elapsed_ticks_next = elapsed_ticks;
    odd_byte_next = odd_byte;
    case (kind)
      K_PROGRAM: if (phase == PH_IDLE) begin
        target_address_next = {addr_w[22:1], 1'b0};
        program_value_next = data;
        burst.item[0] = mk_rd({addr_w[22:1], 1'b0});
        burst.count = 4'd1;
        phase_next = PH_P_CHECK;
      end
      K_ERASE: if (phase == PH_IDLE) begin
        if (range_bad) begin
          burst.item[0] = mk_done(ST_INVALID, 8'd0);
          burst.count = 4'd1;
        end else if (range_prot) begin
          burst.item[0] = mk_done(ST_PROTECTED, 8'd0);
          burst.count = 4'd1;
        end else begin
          current_sector_next = first_sector;
          end_sector_next = last_sector;
          burst.item[0] = mk_wr(UNLOCK_A1, CMD_AA);
          burst.item[1] = mk_wr(UNLOCK_A2, CMD_55);
          burst.item[2] = mk_wr(UNLOCK_A1, CMD_80);
          burst.item[3] = mk_wr(UNLOCK_A1, CMD_AA);
          burst.item[4] = mk_wr(UNLOCK_A2, CMD_55);
          burst.item[5] = mk_wr(first_sa, CMD_30);
          burst.item[6] = mk_rd(first_sa);
          burst.count = 4'd7;
          elapsed_ticks_next = '0;
          phase_next = PH_E_POLL;
        end
      end
      K_SECSI: if (phase == PH_IDLE) begin
        if (bank != 2'd1) begin
          burst.item[0] = mk_done(ST_BAD_BANK, 8'd0);
          burst.count = 4'd1;
        end else begin
          target_address_next = {addr_w[22:1], 1'b0};
          odd_byte_next = addr_w[0];
          burst.item[0] = mk_wr(UNLOCK_A1, CMD_AA);
          burst.item[1] = mk_wr(UNLOCK_A2, CMD_55);
          burst.item[2] = mk_wr(UNLOCK_A1, CMD_88);
          burst.item[3] = mk_rd({addr_w[22:1], 1'b0});
          burst.count = 4'd4;
          phase_next = PH_S_WAIT;
        end
      end
      K_RESP: begin
        unique case (phase)
          PH_IDLE: ;
          PH_P_CHECK: begin
            if ((read_data & program_value) != program_value) begin
              burst.item[0] = mk_done(ST_NOT_ERASED, 8'd0);
              burst.count = 4'd1;
              phase_next = PH_IDLE;
            end else begin
              burst.item[0] = mk_wr(UNLOCK_A1, CMD_AA);
              burst.item[1] = mk_wr(UNLOCK_A2, CMD_55);
              burst.item[2] = mk_wr(UNLOCK_A1, CMD_A0);
              burst.item[3] = mk_wr(target_address, program_value);
              burst.item[4] = mk_rd(target_address);
              burst.count = 4'd5;
              elapsed_ticks_next = '0;
              phase_next = PH_P_POLL;
            end
          end
          PH_P_POLL, PH_P_RECHECK: begin
            if (phase == PH_P_POLL && timed_out) begin
              burst.item[0] = mk_wr(target_address, CMD_F0);
              burst.item[1] = mk_done(ST_TIMEOUT, 8'd0);
              burst.count = 4'd2;
              phase_next = PH_IDLE;
            end else if (read_data[7] == program_value[7]) begin
              burst.item[0] = mk_wr(target_address, CMD_F0);
              burst.item[1] = mk_rd(target_address);
              burst.count = 4'd2;
              phase_next = PH_P_VERIFY;
            end else if (phase == PH_P_RECHECK) begin
              burst.item[0] = mk_wr(target_address, CMD_F0);
              burst.item[1] = mk_done(ST_PROG_ERR, 8'd0);
              burst.count = 4'd2;
              phase_next = PH_IDLE;
            end else begin
              burst.item[0] = mk_rd(target_address);
              burst.count = 4'd1;
              if (read_data[5]) phase_next = PH_P_RECHECK;
            end
          end
          PH_P_VERIFY: begin
            burst.item[0] = mk_done((read_data == program_value) ? ST_OK : ST_PROG_ERR,
                                    8'd0);
            burst.count = 4'd1;
            phase_next = PH_IDLE;
          end
          PH_E_POLL: begin
            if (timed_out) begin
              burst.item[0] = mk_wr(UNLOCK_A1, CMD_F0);
              burst.item[1] = mk_wr(UNLOCK_A1, CMD_F0);
              burst.item[2] = mk_done(ST_TIMEOUT, 8'd0);
              burst.count = 4'd3;
              phase_next = PH_IDLE;
            end else if (read_data[7]) begin
              burst.item[0] = mk_wr(UNLOCK_A1, CMD_F0);
              if (current_sector >= end_sector) begin
                burst.item[1] = mk_done(ST_OK, 8'd0);
                burst.count = 4'd2;
                phase_next = PH_IDLE;
              end else begin
                current_sector_next = nxt_sec;
                burst.item[1] = mk_wr(UNLOCK_A1, CMD_AA);
                burst.item[2] = mk_wr(UNLOCK_A2, CMD_55);
                burst.item[3] = mk_wr(UNLOCK_A1, CMD_80);
                burst.item[4] = mk_wr(UNLOCK_A1, CMD_AA);
                burst.item[5] = mk_wr(UNLOCK_A2, CMD_55);
                burst.item[6] = mk_wr(nxt_sa, CMD_30);
                burst.item[7] = mk_rd(nxt_sa);
                burst.count = 4'd8;
                elapsed_ticks_next = '0;
              end
            end else if (read_data[5]) begin
              burst.item[0] = mk_wr(UNLOCK_A1, CMD_F0);
              burst.item[1] = mk_done(ST_PROG_ERR, 8'd0);
              burst.count = 4'd2;
              phase_next = PH_IDLE;
            end else begin
              burst.item[0] = mk_rd(cur_sa);
              burst.count = 4'd1;
            end
          end
          PH_S_WAIT: begin
            burst.item[0] = mk_wr(UNLOCK_A1, CMD_AA);
            burst.item[1] = mk_wr(UNLOCK_A2, CMD_55);
            burst.item[2] = mk_wr(UNLOCK_A1, CMD_90);
            burst.item[3] = mk_wr(UNLOCK_A1, CMD_00);
            burst.item[4] = mk_done(ST_OK, odd_byte ? read_data[15:8] : read_data[7:0]);
            burst.count = 4'd5;
            phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      K_TICK: if (elapsed_ticks != '1) elapsed_ticks_next = elapsed_ticks + 32'd1;
      default: ;
    endcase
  end

  // advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      current_sector <= '0;
      end_sector <= '0;
      target_address <= '0;
      program_value <= '0;
      elapsed_ticks <= '0;
      odd_byte <= 1'b0;
    end else if (go) begin
      phase <= phase_next;
      current_sector <= current_sector_next;
      end_sector <= end_sector_next;
      target_address <= target_address_next;
      program_value <= program_value_next;
      elapsed_ticks <= elapsed_ticks_next;
      odd_byte <= odd_byte_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  a_tick_clear: assert property (@(posedge clk) disable iff (rst)
    (go && kind == K_RESP && phase == PH_P_CHECK && burst.count == 4'd5)
      |=> elapsed_ticks == '0)
    else $error("poll timer not cleared");
  a_burst_max: assert property (@(posedge clk) disable iff (rst)
    burst.count <= 4'd8) else $error("burst too long");

endmodule

/* src/nfcs_outq.sv */
`timescale 1ns / 1ps
module nfcs_outq import nfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  burst_t      burst_in,
  output logic        empty,
  output logic        m_tvalid,
  input  logic        m_tready,
  output res_t        m_res,
  output logic        m_last
);

  burst_t     buf_q;
  logic [3:0] pos;

  assign empty = (buf_q.count == 4'd0);
  assign m_tvalid = !empty;
  assign m_res = buf_q.item[pos[2:0]];
  assign m_last = (pos + 4'd1 == buf_q.count);

  // hold one burst and stream it out word by word
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_q.count <= '0;
      pos <= '0;
    end else if (m_tvalid && m_tready && m_last) begin
      buf_q.count <= '0;
      pos <= '0;
      if (load) buf_q <= burst_in;
    end else if (m_tvalid && m_tready) begin
      pos <= pos + 4'd1;
    end else if (load && empty) begin
      buf_q <= burst_in;
    end
  end

  a_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pos < buf_q.count) else $error("read past burst");

endmodule

/* src/nor_flash_command_sequencer.sv */
`timescale 1ns / 1ps
// channel | dir | tdata (low first)                                  | tuser | tlast
// s_axis  | in  | address, data, first_sector, last_sector, bank,    | kind  | -
//         |     | read_data                                          |       |
// m_axis  | out | bus_op, bus_address, bus_data, status, read_byte    | done  | last
// cfg     | in  | cfg_we, cfg_index, cfg_data (no read-back)         |       |
// An input word is decoded combinationally into a burst of up to eight result words.
// The burst is held in an output buffer and streamed one word per cycle while m_axis_tready is high.
// A new input is taken in the cycle the buffer's last word leaves or while the buffer is empty.
// Reset is synchronous; it clears state and drops any pending burst.
module nor_flash_command_sequencer import nfcs_pkg::*; #(
  parameter int NUM_SECTORS        = 71,
  parameter int PARAM_SECTOR_BYTES = 4096,
  parameter int MAIN_SECTOR_BYTES  = 65536,
  parameter int FLASH_BYTES        = 8388608
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // address, data, first, last, bank, read_data
  input  logic [2:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // bus_op, bus_address, bus_data, status, read_byte
  output logic        m_axis_tuser,  // done_res
  output logic        m_axis_tlast,  // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [31:0]  timeout_ticks;
  logic [63:0]  protect_low;
  logic [6:0]   protect_high;
  logic         go, empty;
  burst_t       burst;
  res_t         res;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 32'd65535;
      protect_low <= '0;
      protect_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ticks <= cfg_data[31:0];
        REG_PROT_LO: protect_low <= cfg_data;
        REG_PROT_HI: protect_high <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = empty || (m_axis_tready && m_axis_tlast);
  assign go = s_axis_tvalid && s_axis_tready;

  nfcs_core #(
    .NUM_SECTORS(NUM_SECTORS), .PARAM_SECTOR_BYTES(PARAM_SECTOR_BYTES),
    .MAIN_SECTOR_BYTES(MAIN_SECTOR_BYTES), .FLASH_BYTES(FLASH_BYTES)
  ) u_core (
    .clk, .rst, .go,
    .kind(s_axis_tuser),
    .address(s_axis_tdata[22:0]),
    .data(s_axis_tdata[38:23]),
    .first_sector(s_axis_tdata[45:39]),
    .last_sector(s_axis_tdata[52:46]),
    .bank(s_axis_tdata[54:53]),
    .read_data(s_axis_tdata[70:55]),
    .timeout_ticks,
    .protect({57'd0, protect_high, protect_low}),
    .burst
  );

  nfcs_outq u_outq (
    .clk, .rst, .load(go), .burst_in(burst), .empty,
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_res(res), .m_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, res.rbyte, res.status, res.data, res.addr, res.op};
  assign m_axis_tuser = res.done;

endmodule

/* tb/nor_flash_command_sequencer_tb.sv */
`timescale 1ns / 1ps
module nor_flash_command_sequencer_tb;
  import nfcs_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [22:0] address;
    logic [15:0] data;
    logic [6:0]  first_sec;
    logic [6:0]  last_sec;
    logic [1:0]  bank;
    logic [15:0] rdata;
  } request_t;

  typedef struct {
    res_t w;
    logic lst;
  } bus_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TIMEOUT;
  logic [63:0] cfg_data = '0;

  nor_flash_command_sequencer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  request_t  pending_q[$];
  bus_word_t access_q[$];
  res_t      burst_q[$];
  request_t  cur_req;
  int        errors = 0;
  int        tx_idle = 0;
  int        rx_idle = 0;
  logic      rx_hold = 1'b0;
  logic      hold_go = 1'b0;

  // sequencer shadow state and registers
  phase_t      sq_phase;
  logic [6:0]  sq_sec, sq_end;
  logic [22:0] sq_target;
  logic [15:0] sq_value;
  logic [31:0] sq_ticks;
  logic        sq_odd;
  logic [31:0] sq_timeout;
  logic [63:0] sq_prot_lo;
  logic [6:0]  sq_prot_hi;

  task automatic put(logic [1:0] op, logic [22:0] a, logic [15:0] d, logic dn,
                     logic [2:0] st, logic [7:0] b);
    res_t r;
    r.op = op; r.addr = a; r.data = d; r.done = dn; r.status = st; r.rbyte = b;
    burst_q.push_back(r);
  endtask

  task automatic put_wr(logic [22:0] a, logic [15:0] d);
    put(OP_WRITE, a, d, 1'b0, ST_OK, 8'd0);
  endtask

  task automatic put_rd(logic [22:0] a);
    put(OP_READ, a, 16'd0, 1'b0, ST_OK, 8'd0);
  endtask

  task automatic put_done(logic [2:0] st, logic [7:0] b);
    put(OP_NONE, 23'd0, 16'd0, 1'b1, st, b);
    sq_phase = PH_IDLE;
  endtask

  function automatic logic [22:0] sector_base(logic [6:0] s);
    if (s <= 7) return 23'(s * 4096);
    return 23'((s - 7) * 65536);
  endfunction

  task automatic start_erase();
    logic [22:0] sa;
    sa = sector_base(sq_sec);
    put_wr(UNLOCK_A1, CMD_AA); put_wr(UNLOCK_A2, CMD_55); put_wr(UNLOCK_A1, CMD_80);
    put_wr(UNLOCK_A1, CMD_AA); put_wr(UNLOCK_A2, CMD_55); put_wr(sa, CMD_30);
    put_rd(sa);
    sq_ticks = 0;
    sq_phase = PH_E_POLL;
  endtask

  task automatic program_ready();
    put_wr(sq_target, CMD_F0);
    put_rd(sq_target);
    sq_phase = PH_P_VERIFY;
  endtask

  task automatic take_response(logic [15:0] r);
    case (sq_phase)
      PH_P_CHECK: begin
        if ((r & sq_value) != sq_value) put_done(ST_NOT_ERASED, 8'd0);
        else begin
          put_wr(UNLOCK_A1, CMD_AA); put_wr(UNLOCK_A2, CMD_55); put_wr(UNLOCK_A1, CMD_A0);
          put_wr(sq_target, sq_value);
          put_rd(sq_target);
          sq_ticks = 0;
          sq_phase = PH_P_POLL;
        end
      end
      PH_P_POLL: begin
        if (sq_ticks > sq_timeout) begin
          put_wr(sq_target, CMD_F0);
          put_done(ST_TIMEOUT, 8'd0);
        end else if (r[7] == sq_value[7]) program_ready();
        else if (r[5]) begin
          put_rd(sq_target);
          sq_phase = PH_P_RECHECK;
        end else put_rd(sq_target);
      end
      PH_P_RECHECK: begin
        if (r[7] == sq_value[7]) program_ready();
        else begin
          put_wr(sq_target, CMD_F0);
          put_done(ST_PROG_ERR, 8'd0);
        end
      end
      PH_P_VERIFY: put_done((r == sq_value) ? ST_OK : ST_PROG_ERR, 8'd0);
      PH_E_POLL: begin
        if (sq_ticks > sq_timeout) begin
          put_wr(UNLOCK_A1, CMD_F0); put_wr(UNLOCK_A1, CMD_F0);
          put_done(ST_TIMEOUT, 8'd0);
        end else if (r[7]) begin
          put_wr(UNLOCK_A1, CMD_F0);
          if (sq_sec >= sq_end) put_done(ST_OK, 8'd0);
          else begin
            sq_sec = sq_sec + 7'd1;
            start_erase();
          end
        end else if (r[5]) begin
          put_wr(UNLOCK_A1, CMD_F0);
          put_done(ST_PROG_ERR, 8'd0);
        end else put_rd(sector_base(sq_sec));
      end
      PH_S_WAIT: begin
        put_wr(UNLOCK_A1, CMD_AA); put_wr(UNLOCK_A2, CMD_55);
        put_wr(UNLOCK_A1, CMD_90); put_wr(UNLOCK_A1, CMD_00);
        put_done(ST_OK, sq_odd ? r[15:8] : r[7:0]);
      end
      default: sq_phase = PH_IDLE;
    endcase
  endtask

  // work out the bus words one accepted request causes
  task automatic predict_accesses(request_t q);
    logic prot;
    bus_word_t bw;
    burst_q.delete();
    case (q.kind)
      K_PROGRAM: if (sq_phase == PH_IDLE) begin
        sq_target = {q.address[22:1], 1'b0};
        sq_value = q.data;
        put_rd(sq_target);
        sq_phase = PH_P_CHECK;
      end
      K_ERASE: if (sq_phase == PH_IDLE) begin
        if (q.first_sec > q.last_sec || q.last_sec >= 71) put_done(ST_INVALID, 8'd0);
        else begin
          prot = 1'b0;
          for (int s = q.first_sec; s <= q.last_sec; s++)
            prot |= (s < 64) ? sq_prot_lo[s] : sq_prot_hi[s-64];
          if (prot) put_done(ST_PROTECTED, 8'd0);
          else begin
            sq_sec = q.first_sec;
            sq_end = q.last_sec;
            start_erase();
          end
        end
      end
      K_SECSI: if (sq_phase == PH_IDLE) begin
        if (q.bank != 2'd1) put_done(ST_BAD_BANK, 8'd0);
        else begin
          sq_target = {q.address[22:1], 1'b0};
          sq_odd = q.address[0];
          put_wr(UNLOCK_A1, CMD_AA); put_wr(UNLOCK_A2, CMD_55); put_wr(UNLOCK_A1, CMD_88);
          put_rd(sq_target);
          sq_phase = PH_S_WAIT;
        end
      end
      K_RESP: if (sq_phase != PH_IDLE) take_response(q.rdata);
      K_TICK: if (sq_ticks != 32'hFFFF_FFFF) sq_ticks = sq_ticks + 1;
      default: ;
    endcase
    foreach (burst_q[i]) begin
      bw.w = burst_q[i];
      bw.lst = (i == burst_q.size() - 1);
      access_q.push_back(bw);
    end
  endtask

  // drive request words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_accesses(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_req.kind;
          s_axis_tdata <= {1'd0, cur_req.rdata, cur_req.bank, cur_req.last_sec,
                           cur_req.first_sec, cur_req.data, cur_req.address};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // check each bus word against the oldest expectation
  always @(posedge clk) begin
    bus_word_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (access_q.size() == 0) report("unexpected word", m_axis_tdata[31:0], 0);
        else begin
          e = access_q.pop_front();
          if (m_axis_tdata[1:0] != e.w.op) report("bus_op", m_axis_tdata[1:0], e.w.op);
          if (m_axis_tdata[24:2] != e.w.addr)
            report("bus_address", m_axis_tdata[24:2], e.w.addr);
          if (m_axis_tdata[40:25] != e.w.data)
            report("bus_data", m_axis_tdata[40:25], e.w.data);
          if (m_axis_tdata[43:41] != e.w.status)
            report("status", m_axis_tdata[43:41], e.w.status);
          if (m_axis_tdata[51:44] != e.w.rbyte)
            report("read_byte", m_axis_tdata[51:44], e.w.rbyte);
          if (m_axis_tuser != e.w.done) report("done", m_axis_tuser, e.w.done);
          if (m_axis_tlast != e.lst) report("last", m_axis_tlast, e.lst);
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  // long receiver hold-off so the output buffer fills and stalls the input
  initial begin
    @(posedge hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (120) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAIL nor_flash_command_sequencer");
    $finish;
  end

  task automatic push_req(logic [2:0] k, logic [22:0] a, logic [15:0] d, logic [6:0] f,
                          logic [6:0] l, logic [1:0] b, logic [15:0] r);
    request_t q;
    q.kind = k; q.address = a; q.data = d; q.first_sec = f; q.last_sec = l;
    q.bank = b; q.rdata = r;
    pending_q.push_back(q);
  endtask

  task automatic push_resp(logic [15:0] r);
    push_req(K_RESP, $urandom, $urandom, $urandom, $urandom, $urandom, r);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_req(K_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // occasional stray words: busy requests, unknown kinds, ticks
  task automatic push_noise();
    int c;
    c = $urandom_range(19);
    if (c == 0) push_req(3'($urandom_range(2)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
    else if (c == 1) push_req(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
    else if (c == 2) push_ticks(1);
  endtask

  task automatic gen_program(logic [22:0] a, logic [15:0] d);
    logic [15:0] miss;
    push_req(K_PROGRAM, a, d, $urandom, $urandom, $urandom, $urandom);
    push_noise();
    push_resp(($urandom_range(9) < 7) ? 16'hFFFF : 16'($urandom));
    repeat ($urandom_range(3)) begin
      push_ticks($urandom_range(2));
      miss = ({8'd0, ~d[7], 7'd0}) | (16'($urandom) & 16'hFF5F);
      case ($urandom_range(3))
        0: push_resp(miss | 16'h0020);
        1: push_resp(miss);
        default: push_resp({d[15:8], d[7], 7'($urandom)});
      endcase
      push_noise();
    end
    push_resp(($urandom_range(9) < 7) ? d : 16'($urandom));
    // close out whatever poll stage is left
    repeat (3) push_resp({8'd0, ~d[7], 7'h20});
  endtask

  task automatic gen_erase(logic [6:0] f, logic [6:0] l);
    int n;
    push_req(K_ERASE, $urandom, $urandom, f, l, $urandom, $urandom);
    n = (l >= f) ? l - f + 1 : 1;
    if (n > 4) n = 4;
    repeat (n) begin
      repeat ($urandom_range(2)) begin
        push_ticks($urandom_range(2));
        push_resp(16'($urandom) & 16'hFF5F);
      end
      push_noise();
      push_resp(16'($urandom) | 16'h0080);
    end
    repeat (2) push_resp(16'h0020);
  endtask

  task automatic gen_secsi(logic [22:0] a, logic [1:0] b);
    push_req(K_SECSI, a, $urandom, $urandom, $urandom, b, $urandom);
    push_noise();
    push_resp($urandom);
    push_resp(16'h0020);
  endtask

  task automatic gen_random(int n);
    logic [6:0] f;
    repeat (n) begin
      case ($urandom_range(2))
        0: gen_program($urandom, ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom));
        1: begin
          if ($urandom_range(5) == 0) gen_erase($urandom, $urandom);
          else begin
            f = 7'($urandom_range(70));
            gen_erase(f, (f + $urandom_range(2) > 70) ? 7'd70 : 7'(f + $urandom_range(2)));
          end
        end
        default: gen_secsi($urandom, ($urandom_range(3) == 0) ? 2'($urandom) : 2'd1);
      endcase
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || access_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIMEOUT: sq_timeout = v[31:0];
      REG_PROT_LO: sq_prot_lo = v;
      default: sq_prot_hi = v[6:0];
    endcase
  endtask

  task automatic set_regs(logic [31:0] tmo, logic [63:0] lo, logic [6:0] hi);
    write_reg(REG_TIMEOUT, {32'd0, tmo});
    write_reg(REG_PROT_LO, lo);
    write_reg(REG_PROT_HI, {57'd0, hi});
  endtask

  initial begin
    sq_phase = PH_IDLE; sq_sec = 0; sq_end = 0; sq_target = 0; sq_value = 0;
    sq_ticks = 0; sq_odd = 0; sq_timeout = 32'd65535; sq_prot_lo = 0; sq_prot_hi = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every kind, each corner
    set_regs(32'hFFFF_FFFF, 64'd0, 7'd0);
    gen_program(23'h7FFFFF, 16'hFFFF);
    push_req(K_PROGRAM, 23'h000001, 16'h0000, 0, 0, 0, 0);
    push_req(K_ERASE, 0, 0, 7'd5, 7'd5, 0, 0);   // busy, ignored
    push_resp(16'h0000);
    push_resp(16'h0000);
    push_resp(16'h1234);
    gen_erase(7'd9, 7'd8);
    gen_erase(7'd0, 7'd71);
    gen_erase(7'd127, 7'd127);
    gen_erase(7'd70, 7'd70);
    gen_secsi(23'h000003, 2'd0);
    gen_secsi(23'h7FFFFF, 2'd1);
    push_resp(16'hFFFF);                          // stray response
    push_req(3'd5, 0, 0, 0, 0, 0, 0);
    push_req(3'd7, 23'h7FFFFF, 16'hFFFF, 7'h7F, 7'h7F, 2'd3, 16'hFFFF);
    drain();

    tx_idle = 18; rx_idle = 54;
    set_regs(32'd3, {$urandom, $urandom}, 7'($urandom));
    gen_random(3);
    hold_go = 1'b1;
    gen_random(3);
    drain();

    tx_idle = 54; rx_idle = 18;
    set_regs(32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F);
    gen_program(23'h000100, 16'h00FF);
    gen_erase(7'd3, 7'd3);
    gen_random(2);
    drain();
    set_regs(32'($urandom_range(4)), 64'd1 << $urandom_range(63), 7'd1 << $urandom_range(6));
    gen_random(2);
    drain();

    tx_idle = 0; rx_idle = 0;
    set_regs(32'($urandom_range(6, 2)), 64'd0, 7'd0);
    gen_random(2);
    drain();

    if (errors == 0) $display("PASS nor_flash_command_sequencer");
    else $display("FAIL nor_flash_command_sequencer");
    $finish;
  end

endmodule
